/* design/per_frame_latency_statistics_defines.svh */
// Assertion macros for the per-frame latency statistics block.
// Depends on nothing; the including module supplies clk and rst.
`ifndef PER_FRAME_LATENCY_STATISTICS_DEFINES_SVH
`define PER_FRAME_LATENCY_STATISTICS_DEFINES_SVH

// same-cycle implication, off during reset
`define PLF_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("plf: implication check failed");

// next-cycle implication, off during reset
`define PLF_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plf: next-cycle check failed");

`endif

/* design/plf_pkg.sv */
// Shared types and constants for the per-frame latency statistics block.
// No dependencies.
`default_nettype none

package plf_pkg;

  localparam int unsigned SUM_BITS_DEF = 48;
  localparam int unsigned CNT_BITS     = 32;
  localparam int unsigned DUR_BITS     = 32;
  localparam int unsigned FRAME_BITS   = 32;
  localparam int unsigned LIMIT_BITS   = 32;

  localparam logic [LIMIT_BITS-1:0] FRAME_TIME_LIMIT_RST = LIMIT_BITS'(1500000);

  typedef struct packed {
    logic [FRAME_BITS-1:0] frame_number;
    logic [DUR_BITS-1:0]   duration;
  } beat_t;

  function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] a);
    sat_inc = (&a) ? a : a + CNT_BITS'(1);
  endfunction

endpackage

`default_nettype wire

/* design/plf_in_reg.sv */
// Input register stage: captures one beat and holds it until the core takes it.
// Depends on plf_pkg.
`default_nettype none

module plf_in_reg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output      logic                             in_ready,
  input  wire logic [plf_pkg::FRAME_BITS-1:0]   frame_number,
  input  wire logic [plf_pkg::DUR_BITS-1:0]     duration,
  input  wire logic                             advance,
  output      logic                             beat_valid,
  output      plf_pkg::beat_t                   beat
);
  import plf_pkg::*;

  assign in_ready = !beat_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (in_ready) begin
      beat_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat.frame_number <= frame_number;
      beat.duration     <= duration;
    end
  end

endmodule

`default_nettype wire

/* design/plf_core.sv */
// Statistics state and its single-pass update; the state doubles as the result register.
// Depends on plf_pkg.
`default_nettype none

module plf_core #(
  parameter int unsigned SUM_BITS = plf_pkg::SUM_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr_en,
  input  wire logic [plf_pkg::LIMIT_BITS-1:0]   cfg_wr_data,
  input  wire logic                             load,
  input  wire plf_pkg::beat_t                   beat,
  output      logic [plf_pkg::CNT_BITS-1:0]     event_count,
  output      logic [SUM_BITS-1:0]              event_time_sum,
  output      logic [plf_pkg::DUR_BITS-1:0]     event_time_min,
  output      logic [plf_pkg::DUR_BITS-1:0]     event_time_max,
  output      logic [plf_pkg::CNT_BITS-1:0]     frames_counted,
  output      logic [SUM_BITS-1:0]              frame_time_sum,
  output      logic [SUM_BITS-1:0]              frame_time_min,
  output      logic [SUM_BITS-1:0]              frame_time_max,
  output      logic [plf_pkg::CNT_BITS-1:0]     calls_in_max_frame,
  output      logic [plf_pkg::FRAME_BITS-1:0]   frame_of_max,
  output      logic [plf_pkg::CNT_BITS-1:0]     calls_in_last_frame,
  output      logic [plf_pkg::CNT_BITS-1:0]     calls_in_open_frame
);
  import plf_pkg::*;

  logic [LIMIT_BITS-1:0] frame_time_limit;
  logic [FRAME_BITS-1:0] open_frame_id;
  logic [SUM_BITS-1:0]   open_frame_time;
  logic                  frame_started;

  logic [SUM_BITS-1:0]   dur_ext;
  logic [SUM_BITS:0]     all_sum_wide;
  logic [SUM_BITS:0]     open_sum_wide;
  logic [SUM_BITS:0]     closed_sum_wide;
  logic [SUM_BITS-1:0]   all_sum_next;
  logic [SUM_BITS-1:0]   open_time_add;
  logic [SUM_BITS-1:0]   closed_sum_next;
  logic                  same_frame;
  logic                  closing;
  logic                  under_limit;
  logic                  counts;
  logic                  new_max;

  assign dur_ext         = SUM_BITS'(beat.duration);
  assign all_sum_wide    = {1'b0, event_time_sum} + {1'b0, dur_ext};
  assign open_sum_wide   = {1'b0, open_frame_time} + {1'b0, dur_ext};
  assign closed_sum_wide = {1'b0, frame_time_sum} + {1'b0, open_frame_time};
  assign all_sum_next    = all_sum_wide[SUM_BITS] ? '1 : all_sum_wide[SUM_BITS-1:0];
  assign open_time_add   = open_sum_wide[SUM_BITS] ? '1 : open_sum_wide[SUM_BITS-1:0];
  assign closed_sum_next = closed_sum_wide[SUM_BITS] ? '1 : closed_sum_wide[SUM_BITS-1:0];

  assign same_frame  = frame_started && (beat.frame_number == open_frame_id);
  assign closing     = frame_started && !same_frame;
  assign under_limit = open_frame_time < SUM_BITS'(frame_time_limit);
  assign counts      = closing && under_limit;
  assign new_max     = open_frame_time >= frame_time_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_time_limit <= FRAME_TIME_LIMIT_RST;
    end else if (cfg_wr_en) begin
      frame_time_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      event_count         <= '0;
      event_time_sum      <= '0;
      event_time_min      <= '1;
      event_time_max      <= '0;
      frames_counted      <= '0;
      frame_time_sum      <= '0;
      frame_time_min      <= '1;
      frame_time_max      <= '0;
      calls_in_max_frame  <= '0;
      frame_of_max        <= '0;
      calls_in_last_frame <= '0;
      calls_in_open_frame <= '0;
      open_frame_id       <= '0;
      open_frame_time     <= '0;
      frame_started       <= 1'b0;
    end else if (load) begin
      event_count    <= sat_inc(event_count);
      event_time_sum <= all_sum_next;
      if (beat.duration > event_time_max) begin
        event_time_max <= beat.duration;
      end
      if (beat.duration < event_time_min) begin
        event_time_min <= beat.duration;
      end

      if (same_frame) begin
        calls_in_open_frame <= sat_inc(calls_in_open_frame);
        open_frame_time     <= open_time_add;
      end else begin
        calls_in_open_frame <= CNT_BITS'(1);
        open_frame_time     <= dur_ext;
        open_frame_id       <= beat.frame_number;
        frame_started       <= 1'b1;
      end

      if (closing) begin
        calls_in_last_frame <= calls_in_open_frame;
      end

      if (counts) begin
        frames_counted <= sat_inc(frames_counted);
        frame_time_sum <= closed_sum_next;
        if (open_frame_time < frame_time_min) begin
          frame_time_min <= open_frame_time;
        end
        if (new_max) begin
          frame_time_max     <= open_frame_time;
          calls_in_max_frame <= calls_in_open_frame;
          frame_of_max       <= open_frame_id;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* design/per_frame_latency_statistics.sv */
// Per-frame latency statistics, top level: input register, statistics core, output valid.
// Depends on plf_pkg, plf_in_reg, plf_core and per_frame_latency_statistics_defines.svh.
//
// Each input beat carries a frame number and a duration in microseconds. Every beat
// produces exactly one result beat holding the running event statistics (count,
// saturating sum, min, max) and the per-frame statistics over closed frames whose
// total time lies below frame_time_limit.
// A beat accepted into the input register moves into the statistics state once the
// output is free, and the state is then presented on the outputs.
// Throughput: one beat per cycle while out_ready is high; the state is the result register,
// updated by one pass of add/compare logic as a beat moves out of the input register.
// Stall: with out_ready low the result holds, the input register fills, and
// in_ready drops once both are occupied.
// Reset (rst, synchronous): statistics to their initial values, no result pending,
// frame_time_limit to 1500000. cfg_wr_en writes the limit; write only when idle.
`default_nettype none
`include "per_frame_latency_statistics_defines.svh"

module per_frame_latency_statistics #(
  parameter int unsigned SUM_BITS = plf_pkg::SUM_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr_en,
  input  wire logic [plf_pkg::LIMIT_BITS-1:0]   cfg_wr_data,
  input  wire logic                             in_valid,
  output      logic                             in_ready,
  input  wire logic [plf_pkg::FRAME_BITS-1:0]   frame_number,
  input  wire logic [plf_pkg::DUR_BITS-1:0]     duration,
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      logic [plf_pkg::CNT_BITS-1:0]     event_count,
  output      logic [SUM_BITS-1:0]              event_time_sum,
  output      logic [plf_pkg::DUR_BITS-1:0]     event_time_min,
  output      logic [plf_pkg::DUR_BITS-1:0]     event_time_max,
  output      logic [plf_pkg::CNT_BITS-1:0]     frames_counted,
  output      logic [SUM_BITS-1:0]              frame_time_sum,
  output      logic [SUM_BITS-1:0]              frame_time_min,
  output      logic [SUM_BITS-1:0]              frame_time_max,
  output      logic [plf_pkg::CNT_BITS-1:0]     calls_in_max_frame,
  output      logic [plf_pkg::FRAME_BITS-1:0]   frame_of_max,
  output      logic [plf_pkg::CNT_BITS-1:0]     calls_in_last_frame,
  output      logic [plf_pkg::CNT_BITS-1:0]     calls_in_open_frame
);
  import plf_pkg::*;

  logic  beat_valid;
  beat_t beat;
  logic  advance;

  assign advance = beat_valid && (!out_valid || out_ready);

  plf_in_reg u_in_reg (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .frame_number (frame_number),
    .duration     (duration),
    .advance      (advance),
    .beat_valid   (beat_valid),
    .beat         (beat)
  );

  plf_core #(
    .SUM_BITS (SUM_BITS)
  ) u_core (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .load                (advance),
    .beat                (beat),
    .event_count         (event_count),
    .event_time_sum      (event_time_sum),
    .event_time_min      (event_time_min),
    .event_time_max      (event_time_max),
    .frames_counted      (frames_counted),
    .frame_time_sum      (frame_time_sum),
    .frame_time_min      (frame_time_min),
    .frame_time_max      (frame_time_max),
    .calls_in_max_frame  (calls_in_max_frame),
    .frame_of_max        (frame_of_max),
    .calls_in_last_frame (calls_in_last_frame),
    .calls_in_open_frame (calls_in_open_frame)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // a held result must not be overwritten by the next beat
  `PLF_ASSERT_NXT(a_held_result, out_valid && !out_ready, out_valid && $stable(event_count))
  // every loaded beat leaves a nonzero event and open-frame count
  `PLF_ASSERT_NXT(a_count_after_load, advance, event_count != '0 && calls_in_open_frame != '0)
  // once any event is seen, min cannot exceed max
  `PLF_ASSERT_IMP(a_event_min_max, event_count != '0, event_time_min <= event_time_max)
  // no counted frame means the frame maximum is still at its reset value
  `PLF_ASSERT_IMP(a_frame_max_empty, frames_counted == '0, frame_time_max == '0)

endmodule

`default_nettype wire

/* tb/plf_frame_stats_sb.sv */
`timescale 1ns / 1ps
// Scoreboard for the per-frame latency statistics block: its own copy of the
// statistics state, the queue of statistics due and the per-field compare.
// Depends on plf_pkg.

package plf_frame_stats_sb_pkg;
  import plf_pkg::*;

  localparam int unsigned SB = SUM_BITS_DEF;

  typedef logic [SB-1:0]         sum_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;
  typedef logic [DUR_BITS-1:0]   dur_t;
  typedef logic [FRAME_BITS-1:0] frame_t;

  typedef struct packed {
    cnt_t   event_count;
    sum_t   event_time_sum;
    dur_t   event_time_min;
    dur_t   event_time_max;
    cnt_t   frames_counted;
    sum_t   frame_time_sum;
    sum_t   frame_time_min;
    sum_t   frame_time_max;
    cnt_t   calls_in_max_frame;
    frame_t frame_of_max;
    cnt_t   calls_in_last_frame;
    cnt_t   calls_in_open_frame;
  } frame_stats_t;

  class frame_stats_scoreboard;
    logic [LIMIT_BITS-1:0] limit;
    cnt_t   n_events, n_frames, max_calls, last_calls, open_calls;
    sum_t   ev_sum, fr_sum, fr_min, fr_max, open_time;
    dur_t   ev_min, ev_max;
    frame_t max_id, open_id;
    bit     started;
    frame_stats_t stats_due[$];
    int unsigned mismatches;

    function new();
      limit      = FRAME_TIME_LIMIT_RST;
      n_events   = '0;
      n_frames   = '0;
      max_calls  = '0;
      last_calls = '0;
      open_calls = '0;
      ev_sum     = '0;
      fr_sum     = '0;
      fr_min     = '1;
      fr_max     = '0;
      open_time  = '0;
      ev_min     = '1;
      ev_max     = '0;
      max_id     = '0;
      open_id    = '0;
      started    = 1'b0;
      mismatches = 0;
    endfunction

    function void set_limit(logic [LIMIT_BITS-1:0] v);
      limit = v;
    endfunction

    function int unsigned outstanding();
      return stats_due.size();
    endfunction

    function sum_t add_sat(sum_t a, sum_t b);
      logic [SB:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SB] ? '1 : s[SB-1:0];
    endfunction

    function cnt_t inc_sat(cnt_t a);
      return (a == '1) ? a : a + cnt_t'(1);
    endfunction

    // accepted input beat: advance the statistics and queue what is due
    function void add_event(frame_t frame, dur_t dur);
      frame_stats_t e;
      if (started && frame == open_id) begin
        open_calls = inc_sat(open_calls);
        open_time  = add_sat(open_time, sum_t'(dur));
      end else begin
        if (started) begin
          if (open_time < sum_t'(limit)) begin
            n_frames = inc_sat(n_frames);
            fr_sum   = add_sat(fr_sum, open_time);
            if (open_time > fr_max) fr_max = open_time;
            if (open_time < fr_min) fr_min = open_time;
            // ties take over as well
            if (open_time == fr_max) begin
              max_calls = open_calls;
              max_id    = open_id;
            end
          end
          last_calls = open_calls;
        end
        open_id    = frame;
        open_calls = cnt_t'(1);
        open_time  = sum_t'(dur);
        started    = 1'b1;
      end
      n_events = inc_sat(n_events);
      ev_sum   = add_sat(ev_sum, sum_t'(dur));
      if (dur > ev_max) ev_max = dur;
      if (dur < ev_min) ev_min = dur;

      e.event_count         = n_events;
      e.event_time_sum      = ev_sum;
      e.event_time_min      = ev_min;
      e.event_time_max      = ev_max;
      e.frames_counted      = n_frames;
      e.frame_time_sum      = fr_sum;
      e.frame_time_min      = fr_min;
      e.frame_time_max      = fr_max;
      e.calls_in_max_frame  = max_calls;
      e.frame_of_max        = max_id;
      e.calls_in_last_frame = last_calls;
      e.calls_in_open_frame = open_calls;
      stats_due.push_back(e);
    endfunction

    function void flag(string msg);
      mismatches++;
      $error("%s", msg);
    endfunction

    function void cmp(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got)
        flag($sformatf("%s: expected %0h, got %0h", name, want, got));
    endfunction

    function void check_stats(frame_stats_t got);
      frame_stats_t w;
      if (stats_due.size() == 0) begin
        flag("result beat with no statistics due");
        return;
      end
      w = stats_due.pop_front();
      cmp("event_count",         w.event_count,         got.event_count);
      cmp("event_time_sum",      w.event_time_sum,      got.event_time_sum);
      cmp("event_time_min",      w.event_time_min,      got.event_time_min);
      cmp("event_time_max",      w.event_time_max,      got.event_time_max);
      cmp("frames_counted",      w.frames_counted,      got.frames_counted);
      cmp("frame_time_sum",      w.frame_time_sum,      got.frame_time_sum);
      cmp("frame_time_min",      w.frame_time_min,      got.frame_time_min);
      cmp("frame_time_max",      w.frame_time_max,      got.frame_time_max);
      cmp("calls_in_max_frame",  w.calls_in_max_frame,  got.calls_in_max_frame);
      cmp("frame_of_max",        w.frame_of_max,        got.frame_of_max);
      cmp("calls_in_last_frame", w.calls_in_last_frame, got.calls_in_last_frame);
      cmp("calls_in_open_frame", w.calls_in_open_frame, got.calls_in_open_frame);
    endfunction

    function void check_drained();
      if (stats_due.size() != 0)
        flag($sformatf("%0d result beats never arrived", stats_due.size()));
    endfunction
  endclass

endpackage

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Top of the per-frame latency statistics testbench: clock, reset, beat drivers,
// limit writes and the phases of stimulus. Depends on plf_pkg,
// plf_frame_stats_sb_pkg and per_frame_latency_statistics.

module tb_top;
  import plf_pkg::*;
  import plf_frame_stats_sb_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [LIMIT_BITS-1:0]  cfg_wr_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [FRAME_BITS-1:0]  frame_number = '0;
  logic [DUR_BITS-1:0]    duration = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [CNT_BITS-1:0]    event_count;
  logic [SB-1:0]          event_time_sum;
  logic [DUR_BITS-1:0]    event_time_min;
  logic [DUR_BITS-1:0]    event_time_max;
  logic [CNT_BITS-1:0]    frames_counted;
  logic [SB-1:0]          frame_time_sum;
  logic [SB-1:0]          frame_time_min;
  logic [SB-1:0]          frame_time_max;
  logic [CNT_BITS-1:0]    calls_in_max_frame;
  logic [FRAME_BITS-1:0]  frame_of_max;
  logic [CNT_BITS-1:0]    calls_in_last_frame;
  logic [CNT_BITS-1:0]    calls_in_open_frame;

  frame_stats_scoreboard sb = new();
  bit                    idle_on = 1'b1;
  bit                    long_hold = 1'b0;
  logic [FRAME_BITS-1:0] cur_frame = '0;

  always #1 clk = ~clk;

  per_frame_latency_statistics dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .frame_number        (frame_number),
    .duration            (duration),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .event_count         (event_count),
    .event_time_sum      (event_time_sum),
    .event_time_min      (event_time_min),
    .event_time_max      (event_time_max),
    .frames_counted      (frames_counted),
    .frame_time_sum      (frame_time_sum),
    .frame_time_min      (frame_time_min),
    .frame_time_max      (frame_time_max),
    .calls_in_max_frame  (calls_in_max_frame),
    .frame_of_max        (frame_of_max),
    .calls_in_last_frame (calls_in_last_frame),
    .calls_in_open_frame (calls_in_open_frame)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.add_event(frame_number, duration);
      if (out_valid && out_ready)
        sb.check_stats({event_count, event_time_sum, event_time_min, event_time_max,
                        frames_counted, frame_time_sum, frame_time_min, frame_time_max,
                        calls_in_max_frame, frame_of_max, calls_in_last_frame,
                        calls_in_open_frame});
    end
  end

  // result side: ready runs, short stalls, and one long hold on request
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        out_ready = 1'b0;
        repeat (48) @(negedge clk);
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        n = $urandom_range(1, 12);
        repeat (n) @(negedge clk);
      end
    end
  end

  task automatic send_beat(input logic [FRAME_BITS-1:0] f, input logic [DUR_BITS-1:0] d);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid     = 1'b1;
    frame_number = f;
    duration     = d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_BITS-1:0] v);
    wait_drained();
    repeat (3) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.set_limit(v);
  endtask

  // runs of beats grouped into frames; mostly the next frame, sometimes a jump,
  // a revisit of an older number, or more beats for the frame still open
  task automatic run_frames(input int n_items, input logic [DUR_BITS-1:0] dur_cap);
    int sent;
    int calls;
    int pick;
    logic [DUR_BITS-1:0] d;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) cur_frame = cur_frame + 1;
      else if (pick < 17) cur_frame = $urandom;
      else if (pick < 19) cur_frame = cur_frame - $urandom_range(1, 4);
      calls = $urandom_range(1, 8);
      repeat (calls) begin
        pick = $urandom_range(0, 15);
        case (pick)
          0: d = '0;
          1: d = '1;
          2, 3: d = $urandom;
          default: d = $urandom_range(0, dur_cap);
        endcase
        send_beat(cur_frame, d);
        sent++;
      end
    end
  endtask

  initial begin
    logic [LIMIT_BITS-1:0] lim;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed, reset limit of 1500000
    send_beat(32'hFFFF_FFFF, 32'd0);        // first beat opens, closes nothing
    send_beat(32'hFFFF_FFFF, 32'd0);
    send_beat(32'd0, 32'd5);                // zero total ties the reset maximum
    send_beat(32'd1, 32'hFFFF_FFFF);
    send_beat(32'd2, 32'd10);               // frame 1 over the limit
    send_beat(32'd3, 32'd3);
    send_beat(32'd3, 32'd7);
    send_beat(32'd4, 32'd1_499_999);        // frame 3 ties the maximum
    send_beat(32'd5, 32'd1_500_000);        // frame 4 just under the limit
    send_beat(32'd6, 32'd0);                // frame 5 exactly at the limit
    send_beat(32'd6, 32'd0);
    send_beat(32'd4, 32'd1);                // older frame number reopened
    send_beat(32'd4, 32'd2);
    send_beat(32'd4, 32'd3);
    send_beat(32'd7, 32'h8000_0000);
    send_beat(32'd7, 32'h7FFF_FFFF);
    send_beat(32'h5555_5555, 32'hAAAA_AAAA);
    send_beat(32'hAAAA_AAAA, 32'h5555_5555);
    send_beat(32'd0, 32'd0);

    write_limit('0);
    run_frames(150, 32'd1000);
    write_limit('1);
    run_frames(150, 32'h3FFF_FFFF);

    lim = $urandom_range(1000, 3_000_000);
    write_limit(lim);
    run_frames(100, lim / 3);
    long_hold = 1'b1;
    run_frames(60, lim / 3);
    wait_drained();
    run_frames(60, lim / 3);

    write_limit(FRAME_TIME_LIMIT_RST);
    run_frames(160, 32'd600_000);

    // back to back: near-full durations, one frame per beat, then one long frame
    idle_on = 1'b0;
    write_limit('1);
    for (int i = 0; i < 40; i++) begin
      cur_frame = cur_frame + 1;
      send_beat(cur_frame, 32'hFFFF_FFFE);
    end
    cur_frame = cur_frame + 1;
    for (int i = 0; i < 40; i++) send_beat(cur_frame, 32'hFFFF_FFFF);

    lim = $urandom;
    write_limit(lim);
    run_frames(100, lim >> 2);

    wait_drained();
    repeat (16) @(posedge clk);
    sb.check_drained();
    if (sb.mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
